// ----- rtl/pfsd_pkg.sv -----
package pfsd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SYN_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYN_REP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_REP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ICMP_THR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ICMP_REP = 3'd5;

    localparam logic [15:0] RST_SYN_THR  = 16'd20;
    localparam logic [15:0] RST_SYN_REP  = 16'd50;
    localparam logic [6:0]  RST_SCAN_THR = 7'd15;
    localparam logic [6:0]  RST_SCAN_REP = 7'd20;
    localparam logic [15:0] RST_ICMP_THR = 16'd30;
    localparam logic [15:0] RST_ICMP_REP = 16'd50;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_SSH   = 16'd22;
    localparam logic [15:0] PORT_DNS   = 16'd53;
    localparam logic [15:0] PORT_DHCP  = 16'd67;

    typedef logic [3:0] t_cls;
    localparam t_cls CLS_HTTP      = 4'd0;
    localparam t_cls CLS_HTTPS     = 4'd1;
    localparam t_cls CLS_SSH       = 4'd2;
    localparam t_cls CLS_TCP_OTHER = 4'd3;
    localparam t_cls CLS_DNS       = 4'd4;
    localparam t_cls CLS_DHCP      = 4'd5;
    localparam t_cls CLS_UDP_OTHER = 4'd6;
    localparam t_cls CLS_ICMP      = 4'd7;
    localparam t_cls CLS_OTHER     = 4'd8;

    typedef logic [1:0] t_alert;
    localparam t_alert ALERT_NONE   = 2'd0;
    localparam t_alert ALERT_FIRST  = 2'd1;
    localparam t_alert ALERT_REPEAT = 2'd2;

    typedef struct packed {
        logic accept;
        logic srch_start;
        logic srch_step;
        logic sel_hit;
        logic claim;
        logic untracked;
        logic load;
        logic bump;
        logic lvl_cnt;
        logic walk_start;
        logic walk_step;
        logic padd;
        logic lvl_scan;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_tcp;
        logic is_icmp;
        logic syn_pkt;
        logic srch_hit;
        logic srch_last;
        logic free_any;
        logic walk_end;
        logic div_done;
    } t_sts;

    function automatic t_cls classify(logic [7:0] proto, logic [15:0] sp, logic [15:0] dp);
        t_cls c;
        c = CLS_OTHER;
        if (proto == PROTO_TCP) begin
            if (dp == PORT_HTTP || sp == PORT_HTTP)        c = CLS_HTTP;
            else if (dp == PORT_HTTPS || sp == PORT_HTTPS) c = CLS_HTTPS;
            else if (dp == PORT_SSH || sp == PORT_SSH)     c = CLS_SSH;
            else                                           c = CLS_TCP_OTHER;
        end else if (proto == PROTO_UDP) begin
            if (dp == PORT_DNS || sp == PORT_DNS)          c = CLS_DNS;
            else if (dp == PORT_DHCP || sp == PORT_DHCP)   c = CLS_DHCP;
            else                                           c = CLS_UDP_OTHER;
        end else if (proto == PROTO_ICMP) begin
            c = CLS_ICMP;
        end
        return c;
    endfunction

    function automatic t_alert level_of(logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] thr,
                                        logic rep_nz, logic rem_zero);
        t_alert a;
        a = ALERT_NONE;
        if (cnt == thr)                            a = ALERT_FIRST;
        else if (cnt > thr && rep_nz && rem_zero)  a = ALERT_REPEAT;
        return a;
    endfunction

endpackage

// ----- rtl/pfsd_pkt_if.sv -----
interface pfsd_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        syn_flag;
    logic        ack_flag;

    modport source (output valid, src_addr, protocol, src_port, dst_port, syn_flag, ack_flag,
                    input ready);
    modport sink (input valid, src_addr, protocol, src_port, dst_port, syn_flag, ack_flag,
                  output ready);
endinterface

// ----- rtl/pfsd_res_if.sv -----
interface pfsd_res_if;
    logic                 valid;
    logic                 ready;
    pfsd_pkg::t_cls       traffic_class;
    pfsd_pkg::t_alert     syn_alert;
    pfsd_pkg::t_alert     scan_alert;
    pfsd_pkg::t_alert     icmp_alert;
    logic                 untracked;

    modport source (output valid, traffic_class, syn_alert, scan_alert, icmp_alert, untracked,
                    input ready);
    modport sink (input valid, traffic_class, syn_alert, scan_alert, icmp_alert, untracked,
                  output ready);
endinterface

// ----- rtl/pfsd_rem.sv -----
module pfsd_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic        o_zero
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_dvd;
    logic [15:0] r_dvs;
    logic [16:0] r_rem;
    logic [16:0] n_trial;

    // one quotient bit per cycle, remainder only
    assign n_trial = {r_rem[15:0], r_dvd[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            if (n_trial >= {1'b0, r_dvs}) r_rem <= n_trial - {1'b0, r_dvs};
            else                          r_rem <= n_trial;
        end
    end

    assign o_done = r_done;
    assign o_zero = (r_rem == '0);

endmodule

// ----- rtl/pfsd_dp.sv -----
module pfsd_dp #(
    parameter int SOURCES          = 64,
    parameter int PORTS_PER_SOURCE = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pfsd_pkg::t_cmd                     i_cmd,
    output pfsd_pkg::t_sts                     o_sts,
    input  logic                               i_cfg_we,
    input  logic [pfsd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pfsd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [31:0]                        i_src_addr,
    input  logic [7:0]                         i_protocol,
    input  logic [15:0]                        i_src_port,
    input  logic [15:0]                        i_dst_port,
    input  logic                               i_syn_flag,
    input  logic                               i_ack_flag,
    output pfsd_pkg::t_cls                     o_traffic_class,
    output pfsd_pkg::t_alert                   o_syn_alert,
    output pfsd_pkg::t_alert                   o_scan_alert,
    output pfsd_pkg::t_alert                   o_icmp_alert,
    output logic                               o_untracked
);

    localparam int SRC_W      = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int PORT_DEPTH = SOURCES * PORTS_PER_SOURCE;
    localparam int PA_W       = (PORT_DEPTH > 1) ? $clog2(PORT_DEPTH) : 1;
    localparam int PCNT_W     = $clog2(PORTS_PER_SOURCE + 1);
    localparam int CW         = pfsd_pkg::CNT_W;
    localparam logic [SRC_W-1:0]  LAST_SRC = SRC_W'(SOURCES - 1);
    localparam logic [PCNT_W-1:0] PPS_MAX  = PCNT_W'(PORTS_PER_SOURCE);

    // configuration
    logic [15:0] r_syn_thr, r_syn_rep, r_icmp_thr, r_icmp_rep;
    logic [6:0]  r_scan_thr, r_scan_rep;

    // packet under work
    logic [31:0]       r_addr;
    logic [7:0]        r_proto;
    logic [15:0]       r_dp;
    logic              r_syn_pkt;
    pfsd_pkg::t_cls    r_cls;
    pfsd_pkg::t_alert  r_syn_al, r_scan_al, r_icmp_al;
    logic              r_untr;

    // source table
    logic [31:0]       addr_mem [SOURCES];
    logic [CW-1:0]     syn_mem  [SOURCES];
    logic [CW-1:0]     icmp_mem [SOURCES];
    logic [PCNT_W-1:0] pcnt_mem [SOURCES];
    logic [15:0]       port_mem [PORT_DEPTH];
    logic [SOURCES-1:0] r_valid;

    logic [SRC_W-1:0]  r_idx, r_q_idx, r_free_idx, r_ent;
    logic              r_q_vld, r_free_vld;
    logic [31:0]       r_addr_q;
    logic [SRC_W-1:0]  n_free_idx;
    logic              q_is_free;

    logic [CW-1:0]     r_syn_q, r_icmp_q, r_cnt;
    logic [PCNT_W-1:0] r_pcnt_q, r_k, r_n;
    logic [PA_W-1:0]   r_base;
    logic              r_sat;
    logic [15:0]       r_port_q;
    logic              r_pq_vld, r_seen;

    logic [CW-1:0]     n_old, n_cnt;
    logic              n_sat, n_add;
    logic [PCNT_W-1:0] n_pn;

    logic              div_done, div_zero, div_start;
    logic [31:0]       div_dvd;
    logic [15:0]       div_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_syn_thr  <= pfsd_pkg::RST_SYN_THR;
            r_syn_rep  <= pfsd_pkg::RST_SYN_REP;
            r_scan_thr <= pfsd_pkg::RST_SCAN_THR;
            r_scan_rep <= pfsd_pkg::RST_SCAN_REP;
            r_icmp_thr <= pfsd_pkg::RST_ICMP_THR;
            r_icmp_rep <= pfsd_pkg::RST_ICMP_REP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfsd_pkg::REG_SYN_THR:  r_syn_thr  <= i_cfg_data;
                pfsd_pkg::REG_SYN_REP:  r_syn_rep  <= i_cfg_data;
                pfsd_pkg::REG_SCAN_THR: r_scan_thr <= i_cfg_data[6:0];
                pfsd_pkg::REG_SCAN_REP: r_scan_rep <= i_cfg_data[6:0];
                pfsd_pkg::REG_ICMP_THR: r_icmp_thr <= i_cfg_data;
                pfsd_pkg::REG_ICMP_REP: r_icmp_rep <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // lowest free entry: earlier one recorded, else the entry being looked at
    assign q_is_free  = r_q_vld && !r_valid[r_q_idx];
    assign n_free_idx = r_free_vld ? r_free_idx : r_q_idx;

    assign n_old = (r_proto == pfsd_pkg::PROTO_ICMP) ? r_icmp_q : r_syn_q;
    assign n_sat = (n_old == {CW{1'b1}});
    assign n_cnt = n_sat ? n_old : n_old + CW'(1);
    assign n_add = !r_seen && (r_pcnt_q < PPS_MAX);
    assign n_pn  = n_add ? r_pcnt_q + PCNT_W'(1) : r_pcnt_q;

    assign div_start = i_cmd.bump | i_cmd.padd;
    assign div_dvd   = i_cmd.padd ? 32'(n_pn) : n_cnt;
    assign div_dvs   = i_cmd.padd ? 16'(r_scan_rep) :
                       ((r_proto == pfsd_pkg::PROTO_ICMP) ? r_icmp_rep : r_syn_rep);

    pfsd_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_zero     (div_zero)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_idx      <= '0;
            r_q_vld    <= 1'b0;
            r_free_vld <= 1'b0;
            r_k        <= '0;
            r_pq_vld   <= 1'b0;
            r_seen     <= 1'b0;
        end else begin
            if (i_cmd.srch_start) begin
                r_idx      <= '0;
                r_q_vld    <= 1'b0;
                r_free_vld <= 1'b0;
            end else if (i_cmd.srch_step) begin
                r_q_vld <= 1'b1;
                if (r_idx != LAST_SRC) r_idx <= r_idx + SRC_W'(1);
                if (q_is_free && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_q_idx;
                end
            end
            if (i_cmd.claim) r_valid[n_free_idx] <= 1'b1;

            if (i_cmd.walk_start) begin
                r_k      <= '0;
                r_pq_vld <= 1'b0;
                r_seen   <= 1'b0;
            end else if (i_cmd.walk_step) begin
                if (r_k != r_pcnt_q) begin
                    r_pq_vld <= 1'b1;
                    r_k      <= r_k + PCNT_W'(1);
                end else begin
                    r_pq_vld <= 1'b0;
                end
                if (r_pq_vld && r_port_q == r_dp) r_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_step) begin
            r_addr_q <= addr_mem[r_idx];
            r_q_idx  <= r_idx;
        end
        if (i_cmd.claim) addr_mem[n_free_idx] <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_syn_q <= syn_mem[r_ent];
        if (i_cmd.claim)
            syn_mem[n_free_idx] <= '0;
        else if (i_cmd.bump && !n_sat && r_proto != pfsd_pkg::PROTO_ICMP)
            syn_mem[r_ent] <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_icmp_q <= icmp_mem[r_ent];
        if (i_cmd.claim)
            icmp_mem[n_free_idx] <= '0;
        else if (i_cmd.bump && !n_sat && r_proto == pfsd_pkg::PROTO_ICMP)
            icmp_mem[r_ent] <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_pcnt_q <= pcnt_mem[r_ent];
        if (i_cmd.claim)
            pcnt_mem[n_free_idx] <= '0;
        else if (i_cmd.padd && n_add)
            pcnt_mem[r_ent] <= n_pn;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && r_k != r_pcnt_q) r_port_q <= port_mem[r_base + PA_W'(r_k)];
        if (i_cmd.padd && n_add) port_mem[r_base + PA_W'(r_pcnt_q)] <= r_dp;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr    <= i_src_addr;
            r_proto   <= i_protocol;
            r_dp      <= i_dst_port;
            r_syn_pkt <= i_syn_flag && !i_ack_flag;
            r_cls     <= pfsd_pkg::classify(i_protocol, i_src_port, i_dst_port);
            r_syn_al  <= pfsd_pkg::ALERT_NONE;
            r_scan_al <= pfsd_pkg::ALERT_NONE;
            r_icmp_al <= pfsd_pkg::ALERT_NONE;
            r_untr    <= 1'b0;
        end
        if (i_cmd.untracked) r_untr <= 1'b1;
        if (i_cmd.sel_hit)   r_ent  <= r_q_idx;
        if (i_cmd.claim)     r_ent  <= n_free_idx;
        if (i_cmd.load)      r_base <= PA_W'(r_ent) * PA_W'(PORTS_PER_SOURCE);
        if (i_cmd.bump) begin
            r_cnt <= n_cnt;
            r_sat <= n_sat;
        end
        if (i_cmd.padd) r_n <= n_pn;
        if (i_cmd.lvl_cnt) begin
            if (r_proto == pfsd_pkg::PROTO_ICMP)
                r_icmp_al <= r_sat ? pfsd_pkg::ALERT_NONE :
                             pfsd_pkg::level_of(r_cnt, CW'(r_icmp_thr),
                                                r_icmp_rep != '0, div_zero);
            else
                r_syn_al  <= r_sat ? pfsd_pkg::ALERT_NONE :
                             pfsd_pkg::level_of(r_cnt, CW'(r_syn_thr),
                                                r_syn_rep != '0, div_zero);
        end
        if (i_cmd.lvl_scan)
            r_scan_al <= pfsd_pkg::level_of(CW'(r_n), CW'(r_scan_thr),
                                            r_scan_rep != '0, div_zero);
        if (i_cmd.out_load) begin
            o_traffic_class <= r_cls;
            o_syn_alert     <= r_syn_al;
            o_scan_alert    <= r_scan_al;
            o_icmp_alert    <= r_icmp_al;
            o_untracked     <= r_untr;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.is_tcp    = (r_proto == pfsd_pkg::PROTO_TCP);
        o_sts.is_icmp   = (r_proto == pfsd_pkg::PROTO_ICMP);
        o_sts.syn_pkt   = r_syn_pkt;
        o_sts.srch_hit  = r_q_vld && r_valid[r_q_idx] && (r_addr_q == r_addr);
        o_sts.srch_last = r_q_vld && (r_q_idx == LAST_SRC);
        o_sts.free_any  = r_free_vld || q_is_free;
        o_sts.walk_end  = (r_k == r_pcnt_q) && !r_pq_vld;
        o_sts.div_done  = div_done;
    end

endmodule

// ----- rtl/pfsd_ctrl.sv -----
module pfsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pfsd_pkg::t_sts i_sts,
    output pfsd_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_BUMP  = 4'd4;
    localparam logic [3:0] S_DWC   = 4'd5;
    localparam logic [3:0] S_WINIT = 4'd6;
    localparam logic [3:0] S_WALK  = 4'd7;
    localparam logic [3:0] S_PADD  = 4'd8;
    localparam logic [3:0] S_DWS   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_out_vld;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.is_tcp || i_sts.is_icmp) begin
                    o_cmd.srch_start = 1'b1;
                    n_state          = S_SRCH;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.srch_hit) begin
                    o_cmd.sel_hit = 1'b1;
                    n_state       = S_LOAD;
                end else if (i_sts.srch_last) begin
                    if (i_sts.free_any) begin
                        o_cmd.claim = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        o_cmd.untracked = 1'b1;
                        n_state         = S_OUT;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = (i_sts.is_icmp || i_sts.syn_pkt) ? S_BUMP : S_WINIT;
            end
            S_BUMP: begin
                o_cmd.bump = 1'b1;
                n_state    = S_DWC;
            end
            S_DWC: begin
                if (i_sts.div_done) begin
                    o_cmd.lvl_cnt = 1'b1;
                    n_state       = i_sts.is_icmp ? S_OUT : S_WINIT;
                end
            end
            S_WINIT: begin
                o_cmd.walk_start = 1'b1;
                n_state          = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_end) n_state = S_PADD;
            end
            S_PADD: begin
                o_cmd.padd = 1'b1;
                n_state    = S_DWS;
            end
            S_DWS: begin
                if (i_sts.div_done) begin
                    o_cmd.lvl_scan = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load)  r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// ----- rtl/packet_flood_and_scan_detector_core.sv -----
// Classifies one parsed IPv4 header per word and flags SYN floods, ICMP floods and TCP port
// scans per source address. UDP and other packets skip the source table and go from the check state to the output.
// TCP and ICMP packets walk the source table one entry per cycle, then each count check runs
// a 1-bit-per-cycle remainder unit; a TCP packet also walks its stored destination ports one
// per cycle. One packet is in work at a time; a finished word waits in the output register
// while the next packet is accepted.
module packet_flood_and_scan_detector_core #(
    parameter int SOURCES          = 64,
    parameter int PORTS_PER_SOURCE = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pfsd_pkt_if.sink                        i_pkt,
    pfsd_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [pfsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pfsd_pkg::t_cmd cmd;
    pfsd_pkg::t_sts sts;

    pfsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pkt.valid),
        .o_in_ready  (i_pkt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pfsd_dp #(
        .SOURCES          (SOURCES),
        .PORTS_PER_SOURCE (PORTS_PER_SOURCE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_src_addr      (i_pkt.src_addr),
        .i_protocol      (i_pkt.protocol),
        .i_src_port      (i_pkt.src_port),
        .i_dst_port      (i_pkt.dst_port),
        .i_syn_flag      (i_pkt.syn_flag),
        .i_ack_flag      (i_pkt.ack_flag),
        .o_traffic_class (o_res.traffic_class),
        .o_syn_alert     (o_res.syn_alert),
        .o_scan_alert    (o_res.scan_alert),
        .o_icmp_alert    (o_res.icmp_alert),
        .o_untracked     (o_res.untracked)
    );

endmodule
